// File: hw/rtl/ucf_pkg.sv
// ucf_pkg: shared widths, register indexes and the decode result type
// for the utf-8 code point filter. No dependencies.

package ucf_pkg;

	localparam int BYTE_W         = 8;
	localparam int CP_W           = 21;
	localparam int TABLE_ENTRIES  = 21;
	localparam int SLOTS_PER_PACK = 3;
	localparam int PACK_COUNT     = 7;
	localparam int PACK_W         = CP_W * SLOTS_PER_PACK;
	localparam int CNT_W          = 5;
	localparam int CFG_IDX_W      = 3;
	localparam int PACK_IDX_W     = 3;
	localparam int SLOT_W         = 2;
	localparam int HELD_DEPTH     = 4;
	localparam int LEN_W          = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPECIAL_PACK_0 = 3'd1;

	// result of looking at the held bytes from the lead byte on
	typedef struct packed {
		logic [LEN_W-1:0] len;   // wanted length, 0 for a bad lead
		logic             good;  // continuation bytes well formed
		logic [CP_W-1:0]  cp;    // decoded code point
	} ucf_dec_t;

endpackage

// File: hw/rtl/ucf_cfg_regs.sv
// ucf_cfg_regs: removal table count and packed code point registers,
// with one table entry selected for the shared compare. Uses ucf_pkg.

module ucf_cfg_regs import ucf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [PACK_W-1:0]     cfg_wdata,
	input  logic [PACK_IDX_W-1:0] sel_pack,
	input  logic [SLOT_W-1:0]     sel_slot,
	output logic [CP_W-1:0]       entry,
	output logic [CNT_W-1:0]      entry_count
);

	logic [CNT_W-1:0]  count_q;
	logic [PACK_W-1:0] pack_q [PACK_COUNT];
	logic [PACK_W-1:0] pack_sel;
	logic [CFG_IDX_W-1:0] pack_wr_idx;

	assign pack_wr_idx = cfg_idx - REG_SPECIAL_PACK_0;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			for (int i = 0; i < PACK_COUNT; i++) begin
				pack_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_idx == REG_SPECIAL_COUNT) begin
				count_q <= cfg_wdata[CNT_W-1:0];
			end else begin
				pack_q[pack_wr_idx[PACK_IDX_W-1:0]] <= cfg_wdata;
			end
		end
	end

	// count saturates at the table size
	assign entry_count = (count_q > CNT_W'(TABLE_ENTRIES)) ? CNT_W'(TABLE_ENTRIES) : count_q;

	// entry select
	assign pack_sel = pack_q[sel_pack];

	always_comb begin
		unique case (sel_slot)
			2'd0:    entry = pack_sel[0*CP_W +: CP_W];
			2'd1:    entry = pack_sel[1*CP_W +: CP_W];
			2'd2:    entry = pack_sel[2*CP_W +: CP_W];
			default: entry = '0;
		endcase
	end

endmodule

// File: hw/rtl/ucf_decoder.sv
// ucf_decoder: lead byte length, continuation check and code point
// assembly over the held bytes. Uses ucf_pkg.

module ucf_decoder import ucf_pkg::*; (
	input  logic [BYTE_W-1:0] held [HELD_DEPTH],
	output ucf_dec_t          dec
);

	logic [BYTE_W-1:0] lead;
	logic              c1, c2, c3;

	assign lead = held[0];
	assign c1   = (held[1][7:6] == 2'b10);
	assign c2   = (held[2][7:6] == 2'b10);
	assign c3   = (held[3][7:6] == 2'b10);

	// length from the lead byte, then the continuation check and code point
	always_comb begin
		dec = '0;
		priority if (lead[7] == 1'b0) begin
			dec.len  = 3'd1;
			dec.good = 1'b1;
			dec.cp   = CP_W'(lead);
		end else if (lead[7:5] == 3'b110) begin
			dec.len  = 3'd2;
			dec.good = c1;
			dec.cp   = CP_W'({lead[4:0], held[1][5:0]});
		end else if (lead[7:4] == 4'b1110) begin
			dec.len  = 3'd3;
			dec.good = c1 && c2;
			dec.cp   = CP_W'({lead[3:0], held[1][5:0], held[2][5:0]});
		end else if (lead[7:3] == 5'b11110) begin
			dec.len  = 3'd4;
			dec.good = c1 && c2 && c3;
			dec.cp   = {lead[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
		end else begin
			dec.len  = 3'd0;
			dec.good = 1'b0;
			dec.cp   = '0;
		end
	end

endmodule

// File: hw/rtl/utf8_codepoint_filter.sv
// utf8_codepoint_filter: top level, held byte buffer, scan sequencer and
// output register. Uses ucf_pkg, ucf_cfg_regs and ucf_decoder.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid in_ready in_byte in_last        | into block
//   out     | out_valid out_ready out_byte out_has_byte out_last | out of block
//   cfg     | cfg_we cfg_idx cfg_wdata                 | into block
//
// Each byte is taken in the idle state and then scanned; each complete
// sequence is checked against the table one entry per cycle through the
// shared comparator (count capped at 21), stopping early on a hit, and
// each byte sent passes through the emit state.
// in_ready is high only while the sequencer waits for the next byte.
// A stalled out_ready holds the sequencer at its next send or at the flush.
// Reset clears the table, the held count and all control state.

module utf8_codepoint_filter import ucf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    in_byte,
	input  logic                 in_last,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_has_byte,
	output logic                 out_last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [PACK_W-1:0]    cfg_wdata
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_MATCH = 5'b00100,
		S_EMIT  = 5'b01000,
		S_FIN   = 5'b10000
	} ucf_state_t;

	ucf_state_t state_q;

	logic [BYTE_W-1:0]     held_q [HELD_DEPTH];
	logic [LEN_W-1:0]      count_q;
	logic                  last_q;
	logic [LEN_W-1:0]      emit_left_q;
	logic                  emit_tail_q;
	logic [CNT_W-1:0]      k_q;
	logic [PACK_IDX_W-1:0] pack_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  pend_valid_q;
	logic [BYTE_W-1:0]     pend_byte_q;
	logic                  out_valid_q;
	logic [BYTE_W-1:0]     out_byte_q;
	logic                  out_has_q;
	logic                  out_last_q;

	ucf_dec_t              dec;
	logic [CP_W-1:0]       entry;
	logic [CNT_W-1:0]      entry_count;
	logic                  out_free;
	logic                  can_push;
	logic [LEN_W-1:0]      drop_n;
	logic [HELD_DEPTH*BYTE_W-1:0] held_vec;
	logic [HELD_DEPTH*BYTE_W-1:0] drop_vec;

	ucf_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.sel_pack    (pack_q),
		.sel_slot    (slot_q),
		.entry       (entry),
		.entry_count (entry_count)
	);

	ucf_decoder u_dec (
		.held (held_q),
		.dec  (dec)
	);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_has_byte = out_has_q;
	assign out_last     = out_last_q;

	assign out_free = !out_valid_q || out_ready;
	assign can_push = !pend_valid_q || out_free;

	// front drop of the held buffer: a whole sequence on a table hit, else one byte
	assign drop_n = (state_q == S_MATCH) ? dec.len : 3'd1;

	always_comb begin
		for (int i = 0; i < HELD_DEPTH; i++) begin
			held_vec[i*BYTE_W +: BYTE_W] = held_q[i];
		end
	end

	assign drop_vec = held_vec >> {drop_n, 3'b000};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			last_q       <= 1'b0;
			emit_left_q  <= '0;
			emit_tail_q  <= 1'b0;
			k_q          <= '0;
			pack_q       <= '0;
			slot_q       <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			// output transfer frees the register
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						held_q[count_q[1:0]] <= in_byte;
						count_q <= count_q + 3'd1;
						last_q  <= in_last;
						state_q <= S_SCAN;
					end
				end

				S_SCAN: begin
					if (count_q == '0 || (dec.len != '0 && count_q < dec.len)) begin
						// nothing complete left: tail flush on the last byte
						if (last_q && count_q != '0) begin
							emit_left_q <= count_q;
							emit_tail_q <= 1'b1;
							state_q     <= S_EMIT;
						end else begin
							state_q <= S_FIN;
						end
					end else if (dec.len == '0) begin
						// bad lead byte is dropped
						for (int i = 0; i < HELD_DEPTH; i++) begin
							held_q[i] <= drop_vec[i*BYTE_W +: BYTE_W];
						end
						count_q <= count_q - 3'd1;
					end else if (!dec.good) begin
						// bad continuation: lead goes out alone
						emit_left_q <= 3'd1;
						emit_tail_q <= 1'b0;
						state_q     <= S_EMIT;
					end else begin
						k_q     <= '0;
						pack_q  <= '0;
						slot_q  <= '0;
						state_q <= S_MATCH;
					end
				end

				S_MATCH: begin
					if (k_q >= entry_count) begin
						// no table hit: send the sequence unchanged
						emit_left_q <= dec.len;
						emit_tail_q <= 1'b0;
						state_q     <= S_EMIT;
					end else if (entry == dec.cp) begin
						// table hit: drop the whole sequence
						for (int i = 0; i < HELD_DEPTH; i++) begin
							held_q[i] <= drop_vec[i*BYTE_W +: BYTE_W];
						end
						count_q <= count_q - dec.len;
						state_q <= S_SCAN;
					end else begin
						k_q <= k_q + 5'd1;
						if (slot_q == SLOT_W'(SLOTS_PER_PACK - 1)) begin
							slot_q <= '0;
							pack_q <= pack_q + 3'd1;
						end else begin
							slot_q <= slot_q + 2'd1;
						end
					end
				end

				S_EMIT: begin
					// newest byte waits in pend so the final one can take the last flag
					if (can_push) begin
						if (pend_valid_q) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= pend_byte_q;
							out_has_q   <= 1'b1;
							out_last_q  <= 1'b0;
						end
						pend_valid_q <= 1'b1;
						pend_byte_q  <= held_q[0];
						for (int i = 0; i < HELD_DEPTH; i++) begin
							held_q[i] <= drop_vec[i*BYTE_W +: BYTE_W];
						end
						count_q     <= count_q - 3'd1;
						emit_left_q <= emit_left_q - 3'd1;
						if (emit_left_q == 3'd1) begin
							state_q <= emit_tail_q ? S_FIN : S_SCAN;
						end
					end
				end

				S_FIN: begin
					if (out_free) begin
						if (pend_valid_q) begin
							out_valid_q  <= 1'b1;
							out_byte_q   <= pend_byte_q;
							out_has_q    <= 1'b1;
							out_last_q   <= last_q;
							pend_valid_q <= 1'b0;
						end else if (last_q) begin
							// bare end marker
							out_valid_q <= 1'b1;
							out_byte_q  <= '0;
							out_has_q   <= 1'b0;
							out_last_q  <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
